// ===== rtl/dmcpi_pkg.sv =====
// Shared widths, constants and sequencer types of the dual motor current loop.
package dmcpi_pkg;

   localparam int ADC_BITS_DEF = 12;

   localparam int FS_W   = 12;
   localparam int OFS_W  = 12;
   localparam int GAIN_W = 24;
   localparam int COEF_W = 24;
   localparam int PWM_W  = 15;
   localparam int SP_W   = 16;
   localparam int CUR_W  = 16;
   localparam int CMP_W  = 16;
   localparam int ERR_W  = 17;
   localparam int VOLT_W = 32;
   localparam int DIFF_W = 13;
   localparam int MV_Q_W = 12;

   localparam int ACC_W  = 48;
   localparam int MC_W   = 33;
   localparam int MPLR_W = 17;
   localparam int REM_W  = 16;
   localparam int STEP_W = 5;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 24;

   localparam int V_LIMIT   = 24000 * 65536;
   localparam int V_DUTY    = 19200 * 65536;
   localparam int DUTY_DIVR = 24000;
   localparam int CUR_MAX   = 32767;
   localparam int CUR_MIN   = -32768;
   localparam int TRUNC_W   = 16;

   typedef enum logic [CSR_AW-1:0] {
      CSR_FULL_SCALE,
      CSR_OFFSET_M1,
      CSR_OFFSET_M2,
      CSR_GAIN_M1,
      CSR_GAIN_M2,
      CSR_COEF_NEW,
      CSR_COEF_OLD,
      CSR_PWM_HALF
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_MV_MUL,
      PH_MV_DIV,
      PH_CUR_MUL,
      PH_CUR_FIX,
      PH_PI_MUL,
      PH_PI_ADD,
      PH_DUTY_MUL,
      PH_DUTY_DIV
   } phase_type;

   typedef struct packed {
      phase_type phase;
      logic      first;
   } seq_type;

endpackage

// ===== rtl/dmcpi_lane.sv =====
// One motor lane: bit-serial current scaling, Tustin PI update and PWM compare.
module dmcpi_lane #(
   parameter int ADC_BITS = dmcpi_pkg::ADC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  dmcpi_pkg::seq_type                    seq,
   input  logic [ADC_BITS-1:0]                   adc,
   input  logic signed [dmcpi_pkg::SP_W-1:0]     setpoint,
   input  logic [dmcpi_pkg::FS_W-1:0]            full_scale,
   input  logic [dmcpi_pkg::OFS_W-1:0]           offset,
   input  logic [dmcpi_pkg::GAIN_W-1:0]          gain,
   input  logic signed [dmcpi_pkg::COEF_W-1:0]   coef_new,
   input  logic signed [dmcpi_pkg::COEF_W-1:0]   coef_old,
   input  logic signed [dmcpi_pkg::COEF_W:0]     coef_sum,
   input  logic [dmcpi_pkg::PWM_W-1:0]           pwm_half,
   output logic [dmcpi_pkg::CMP_W-1:0]           compare,
   output logic signed [dmcpi_pkg::CUR_W-1:0]    current,
   output logic                                  volt_sat
);
   import dmcpi_pkg::*;

   localparam logic [REM_W-1:0]        ADC_FULL  = REM_W'((1 << ADC_BITS) - 1);
   localparam logic [REM_W-1:0]        DUTY_D    = REM_W'(DUTY_DIVR);
   localparam logic signed [ACC_W-1:0] V_MAX     = ACC_W'(V_LIMIT);
   localparam logic signed [ACC_W-1:0] V_MIN     = -V_MAX;
   localparam logic signed [ACC_W-1:0] C_MAX     = ACC_W'(CUR_MAX);
   localparam logic signed [ACC_W-1:0] C_MIN     = ACC_W'(CUR_MIN);
   localparam logic signed [ACC_W-1:0] T_BIAS    = ACC_W'((1 << TRUNC_W) - 1);
   localparam logic signed [VOLT_W-1:0] D_MAX    = VOLT_W'(V_DUTY);
   localparam logic signed [VOLT_W-1:0] D_MIN    = -D_MAX;
   localparam logic [VOLT_W-1:0]        V_SPAN   = VOLT_W'(V_LIMIT);

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [MPLR_W-1:0]        mplr_ff, mplr_in;
   logic [MPLR_W-1:0]        mplr2_ff, mplr2_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [REM_W-1:0]         low_ff, low_in;
   logic [CMP_W-1:0]         quo_ff, quo_in;
   logic signed [CUR_W-1:0]  cur_ff, cur_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [ERR_W-1:0]  perr_ff, perr_in;
   logic signed [VOLT_W-1:0] pvolt_ff, pvolt_in;
   logic                     sat_ff, sat_in;

   logic [MPLR_W-1:0]        mul_load, mul_load2, cur_mplr, cur_mplr2;
   logic signed [MC_W-1:0]   mc;
   logic                     msigned;
   logic signed [ACC_W-1:0]  addend, base, mul_acc;
   logic [REM_W-1:0]         rem_load, low_load, divisor, cur_rem, cur_low, quo_base;
   logic [REM_W:0]           trial, trial_diff;
   logic                     qbit;
   logic [DIFF_W-1:0]        mv_diff;
   logic signed [VOLT_W-1:0] duty_vc;
   logic [VOLT_W-1:0]        duty_span;
   logic signed [ACC_W-1:0]  rnd, quot, volt_sum, volt_clip;

   assign mv_diff   = {1'b0, quo_ff[MV_Q_W-1:0]} - {1'b0, offset};
   assign duty_vc   = (pvolt_ff > D_MAX) ? D_MAX : ((pvolt_ff < D_MIN) ? D_MIN : pvolt_ff);
   assign duty_span = V_SPAN + $unsigned(duty_vc);

   always_comb begin
      mul_load  = '0;
      mul_load2 = '0;
      mc        = '0;
      msigned   = 1'b0;
      rem_load  = '0;
      low_load  = '0;
      divisor   = '0;
      unique case (seq.phase)
         PH_MV_MUL: begin
            mul_load = {full_scale, {(MPLR_W-FS_W){1'b0}}};
            mc       = MC_W'(adc);
         end
         PH_MV_DIV: begin
            rem_load = REM_W'(acc_ff[ADC_BITS+MV_Q_W-1:MV_Q_W]);
            low_load = {acc_ff[MV_Q_W-1:0], {(REM_W-MV_Q_W){1'b0}}};
            divisor  = ADC_FULL;
         end
         PH_CUR_MUL: begin
            mul_load = {mv_diff, {(MPLR_W-DIFF_W){1'b0}}};
            mc       = MC_W'(gain);
            msigned  = 1'b1;
         end
         PH_PI_MUL: begin
            mul_load  = err_ff;
            mul_load2 = perr_ff;
            msigned   = 1'b1;
         end
         PH_DUTY_MUL: begin
            mul_load = {pwm_half, {(MPLR_W-PWM_W){1'b0}}};
            mc       = MC_W'(duty_span);
         end
         PH_DUTY_DIV: begin
            rem_load = acc_ff[2*REM_W+REM_W-1:2*REM_W];
            low_load = acc_ff[2*REM_W-1:REM_W];
            divisor  = DUTY_D;
         end
         default: ;
      endcase
   end

   assign cur_mplr  = seq.first ? mul_load : mplr_ff;
   assign cur_mplr2 = seq.first ? mul_load2 : mplr2_ff;

   always_comb begin
      if (seq.phase == PH_PI_MUL) begin
         case ({cur_mplr[MPLR_W-1], cur_mplr2[MPLR_W-1]})
            2'b10:   addend = ACC_W'(coef_new);
            2'b01:   addend = ACC_W'(coef_old);
            2'b11:   addend = ACC_W'(coef_sum);
            default: addend = '0;
         endcase
      end else begin
         addend = cur_mplr[MPLR_W-1] ? ACC_W'(mc) : '0;
      end
   end

   assign base    = seq.first ? '0 : (acc_ff <<< 1);
   assign mul_acc = (msigned && seq.first) ? (base - addend) : (base + addend);

   assign cur_rem    = seq.first ? rem_load : rem_ff;
   assign cur_low    = seq.first ? low_load : low_ff;
   assign quo_base   = seq.first ? '0 : quo_ff;
   assign trial      = {cur_rem, cur_low[REM_W-1]};
   assign trial_diff = trial - {1'b0, divisor};
   assign qbit       = ~trial_diff[REM_W];

   assign rnd       = acc_ff + (acc_ff[ACC_W-1] ? T_BIAS : '0);
   assign quot      = rnd >>> TRUNC_W;
   assign volt_sum  = acc_ff + ACC_W'(pvolt_ff);
   assign volt_clip = (volt_sum > V_MAX) ? V_MAX : ((volt_sum < V_MIN) ? V_MIN : volt_sum);

   always_comb begin
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      mplr2_in = mplr2_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      cur_in   = cur_ff;
      err_in   = err_ff;
      perr_in  = perr_ff;
      pvolt_in = pvolt_ff;
      sat_in   = sat_ff;
      unique case (seq.phase)
         PH_MV_MUL, PH_CUR_MUL, PH_PI_MUL, PH_DUTY_MUL: begin
            acc_in   = mul_acc;
            mplr_in  = cur_mplr << 1;
            mplr2_in = cur_mplr2 << 1;
         end
         PH_MV_DIV, PH_DUTY_DIV: begin
            rem_in = qbit ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
            low_in = cur_low << 1;
            quo_in = {quo_base[CMP_W-2:0], qbit};
         end
         PH_CUR_FIX: begin
            if (quot > C_MAX) begin
               cur_in = CUR_W'(CUR_MAX);
            end else if (quot < C_MIN) begin
               cur_in = CUR_W'(CUR_MIN);
            end else begin
               cur_in = quot[CUR_W-1:0];
            end
            err_in = {setpoint[SP_W-1], setpoint} - {cur_in[CUR_W-1], cur_in};
         end
         PH_PI_ADD: begin
            sat_in   = (volt_sum > V_MAX) || (volt_sum < V_MIN);
            pvolt_in = volt_clip[VOLT_W-1:0];
            perr_in  = err_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         perr_ff  <= '0;
         pvolt_ff <= '0;
      end else begin
         perr_ff  <= perr_in;
         pvolt_ff <= pvolt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mplr_ff  <= mplr_in;
      mplr2_ff <= mplr2_in;
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      quo_ff   <= quo_in;
      cur_ff   <= cur_in;
      err_ff   <= err_in;
      sat_ff   <= sat_in;
   end

   assign compare  = quo_ff;
   assign current  = cur_ff;
   assign volt_sat = sat_ff;

endmodule

// ===== rtl/dual_motor_current_pi_pwm.sv =====
// Top level of the dual motor current loop: registers, sequencer, lanes and result register.
// Each request carries one ADC sample and one setpoint per motor; both motors run side by
// side in two identical bit-serial lanes that share one sequencer. A request is taken, then
// arithmetic follows in phases (sample multiply, divide by the ADC full code, gain multiply,
// current truncate, PI multiply, PI sum, duty multiply, divide), one radix-2 step per cycle
// in each lane's shift-add multiplier and restoring divider, and the result then moves into
// the output register once that register is free. The next request is taken the cycle after
// that, so a new request waits until the previous one is through, while the previous result
// may still wait in the output register. req_stall is high while a request is in work.
module dual_motor_current_pi_pwm #(
   parameter int ADC_BITS = dmcpi_pkg::ADC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ADC_BITS-1:0]                  req_adc_m1,
   input  logic [ADC_BITS-1:0]                  req_adc_m2,
   input  logic signed [dmcpi_pkg::SP_W-1:0]    req_setpoint_m1,
   input  logic signed [dmcpi_pkg::SP_W-1:0]    req_setpoint_m2,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dmcpi_pkg::CMP_W-1:0]          rsp_compare_m1,
   output logic [dmcpi_pkg::CMP_W-1:0]          rsp_compare_m2,
   output logic signed [dmcpi_pkg::CUR_W-1:0]   rsp_current_m1,
   output logic signed [dmcpi_pkg::CUR_W-1:0]   rsp_current_m2,
   output logic                                 rsp_volt_sat_m1,
   output logic                                 rsp_volt_sat_m2,
   input  logic                                 csr_wr_en,
   input  logic [dmcpi_pkg::CSR_AW-1:0]         csr_index,
   input  logic [dmcpi_pkg::CSR_DW-1:0]         csr_wr_data
);
   import dmcpi_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   function automatic logic [STEP_W-1:0] last_step(phase_type ph);
      logic [STEP_W-1:0] n;
      unique case (ph)
         PH_MV_MUL:   n = STEP_W'(FS_W - 1);
         PH_MV_DIV:   n = STEP_W'(MV_Q_W - 1);
         PH_CUR_MUL:  n = STEP_W'(DIFF_W - 1);
         PH_PI_MUL:   n = STEP_W'(ERR_W - 1);
         PH_DUTY_MUL: n = STEP_W'(PWM_W - 1);
         PH_DUTY_DIV: n = STEP_W'(CMP_W - 1);
         default:     n = '0;
      endcase
      return n;
   endfunction

   function automatic phase_type next_phase(phase_type ph);
      phase_type n;
      unique case (ph)
         PH_MV_MUL:   n = PH_MV_DIV;
         PH_MV_DIV:   n = PH_CUR_MUL;
         PH_CUR_MUL:  n = PH_CUR_FIX;
         PH_CUR_FIX:  n = PH_PI_MUL;
         PH_PI_MUL:   n = PH_PI_ADD;
         PH_PI_ADD:   n = PH_DUTY_MUL;
         PH_DUTY_MUL: n = PH_DUTY_DIV;
         default:     n = PH_IDLE;
      endcase
      return n;
   endfunction

   logic [FS_W-1:0]          full_scale_ff;
   logic [OFS_W-1:0]         offset_m1_ff, offset_m2_ff;
   logic [GAIN_W-1:0]        gain_m1_ff, gain_m2_ff;
   logic signed [COEF_W-1:0] coef_new_ff, coef_old_ff;
   logic signed [COEF_W:0]   coef_sum_ff;
   logic [PWM_W-1:0]         pwm_half_ff;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [ADC_BITS-1:0]      adc_m1_ff, adc_m1_in, adc_m2_ff, adc_m2_in;
   logic signed [SP_W-1:0]   sp_m1_ff, sp_m1_in, sp_m2_ff, sp_m2_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CMP_W-1:0]         cmp_m1_ff, cmp_m1_in, cmp_m2_ff, cmp_m2_in;
   logic signed [CUR_W-1:0]  cur_m1_ff, cur_m1_in, cur_m2_ff, cur_m2_in;
   logic                     sat_m1_ff, sat_m1_in, sat_m2_ff, sat_m2_in;

   seq_type                  seq;
   logic                     out_free;
   logic [CMP_W-1:0]         lane_cmp_m1, lane_cmp_m2;
   logic signed [CUR_W-1:0]  lane_cur_m1, lane_cur_m2;
   logic                     lane_sat_m1, lane_sat_m2;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FS_W'(3000);
         offset_m1_ff  <= OFS_W'(1250);
         offset_m2_ff  <= OFS_W'(1250);
         gain_m1_ff    <= GAIN_W'(65536);
         gain_m2_ff    <= GAIN_W'(65536);
         coef_new_ff   <= COEF_W'(65536);
         coef_old_ff   <= COEF_W'(-65536);
         pwm_half_ff   <= PWM_W'(1800);
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FULL_SCALE: full_scale_ff <= csr_wr_data[FS_W-1:0];
            CSR_OFFSET_M1:  offset_m1_ff  <= csr_wr_data[OFS_W-1:0];
            CSR_OFFSET_M2:  offset_m2_ff  <= csr_wr_data[OFS_W-1:0];
            CSR_GAIN_M1:    gain_m1_ff    <= csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_M2:    gain_m2_ff    <= csr_wr_data[GAIN_W-1:0];
            CSR_COEF_NEW:   coef_new_ff   <= csr_wr_data[COEF_W-1:0];
            CSR_COEF_OLD:   coef_old_ff   <= csr_wr_data[COEF_W-1:0];
            CSR_PWM_HALF:   pwm_half_ff   <= csr_wr_data[PWM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      coef_sum_ff <= (COEF_W+1)'(coef_new_ff) + (COEF_W+1)'(coef_old_ff);
   end

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign seq.phase = phase_ff;
   assign seq.first = (step_ff == '0);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      adc_m1_in    = adc_m1_ff;
      adc_m2_in    = adc_m2_ff;
      sp_m1_in     = sp_m1_ff;
      sp_m2_in     = sp_m2_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmp_m1_in    = cmp_m1_ff;
      cmp_m2_in    = cmp_m2_ff;
      cur_m1_in    = cur_m1_ff;
      cur_m2_in    = cur_m2_ff;
      sat_m1_in    = sat_m1_ff;
      sat_m2_in    = sat_m2_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in  = ST_RUN;
               phase_in  = PH_MV_MUL;
               step_in   = '0;
               adc_m1_in = req_adc_m1;
               adc_m2_in = req_adc_m2;
               sp_m1_in  = req_setpoint_m1;
               sp_m2_in  = req_setpoint_m2;
            end
         end
         ST_RUN: begin
            if (step_ff == last_step(phase_ff)) begin
               step_in = '0;
               if (phase_ff == PH_DUTY_DIV) begin
                  phase_in = PH_IDLE;
                  state_in = ST_HOLD;
               end else begin
                  phase_in = next_phase(phase_ff);
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               cmp_m1_in    = lane_cmp_m1;
               cmp_m2_in    = lane_cmp_m2;
               cur_m1_in    = lane_cur_m1;
               cur_m2_in    = lane_cur_m2;
               sat_m1_in    = lane_sat_m1;
               sat_m2_in    = lane_sat_m2;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      adc_m1_ff <= adc_m1_in;
      adc_m2_ff <= adc_m2_in;
      sp_m1_ff  <= sp_m1_in;
      sp_m2_ff  <= sp_m2_in;
      cmp_m1_ff <= cmp_m1_in;
      cmp_m2_ff <= cmp_m2_in;
      cur_m1_ff <= cur_m1_in;
      cur_m2_ff <= cur_m2_in;
      sat_m1_ff <= sat_m1_in;
      sat_m2_ff <= sat_m2_in;
   end

   dmcpi_lane #(
      .ADC_BITS(ADC_BITS)
   ) u_lane_m1 (
      .clock      (clock),
      .reset      (reset),
      .seq        (seq),
      .adc        (adc_m1_ff),
      .setpoint   (sp_m1_ff),
      .full_scale (full_scale_ff),
      .offset     (offset_m1_ff),
      .gain       (gain_m1_ff),
      .coef_new   (coef_new_ff),
      .coef_old   (coef_old_ff),
      .coef_sum   (coef_sum_ff),
      .pwm_half   (pwm_half_ff),
      .compare    (lane_cmp_m1),
      .current    (lane_cur_m1),
      .volt_sat   (lane_sat_m1)
   );

   dmcpi_lane #(
      .ADC_BITS(ADC_BITS)
   ) u_lane_m2 (
      .clock      (clock),
      .reset      (reset),
      .seq        (seq),
      .adc        (adc_m2_ff),
      .setpoint   (sp_m2_ff),
      .full_scale (full_scale_ff),
      .offset     (offset_m2_ff),
      .gain       (gain_m2_ff),
      .coef_new   (coef_new_ff),
      .coef_old   (coef_old_ff),
      .coef_sum   (coef_sum_ff),
      .pwm_half   (pwm_half_ff),
      .compare    (lane_cmp_m2),
      .current    (lane_cur_m2),
      .volt_sat   (lane_sat_m2)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_compare_m1  = cmp_m1_ff;
   assign rsp_compare_m2  = cmp_m2_ff;
   assign rsp_current_m1  = cur_m1_ff;
   assign rsp_current_m2  = cur_m2_ff;
   assign rsp_volt_sat_m1 = sat_m1_ff;
   assign rsp_volt_sat_m2 = sat_m2_ff;

endmodule

// ===== tb/tb_dual_motor_current_pi_pwm.sv =====
// Self-checking testbench for the dual motor current PI loop with PWM compare output.
module tb_dual_motor_current_pi_pwm;
   import dmcpi_pkg::*;

   localparam int     ADC_W        = ADC_BITS_DEF;
   localparam longint ADC_FULL     = (64'sd1 << ADC_W) - 1;
   localparam longint VOLT_LIM     = 64'sd24000 * 65536;
   localparam longint DUTY_LIM     = 64'sd19200 * 65536;
   localparam int     HOLD_AT      = 40;
   localparam int     LONG_HOLD    = 400;
   localparam int     LIMIT_CYCLES = 800000;

   typedef struct packed {
      logic [ADC_W-1:0]       adc_m1;
      logic [ADC_W-1:0]       adc_m2;
      logic signed [SP_W-1:0] sp_m1;
      logic signed [SP_W-1:0] sp_m2;
   } loop_req_type;

   typedef struct packed {
      logic [CMP_W-1:0]        compare_m1;
      logic [CMP_W-1:0]        compare_m2;
      logic signed [CUR_W-1:0] current_m1;
      logic signed [CUR_W-1:0] current_m2;
      logic                    volt_sat_m1;
      logic                    volt_sat_m2;
   } loop_rsp_type;

   typedef struct packed {
      logic [CMP_W-1:0]        compare;
      logic signed [CUR_W-1:0] current;
      logic                    sat;
   } motor_out_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [ADC_W-1:0]        req_adc_m1 = '0;
   logic [ADC_W-1:0]        req_adc_m2 = '0;
   logic signed [SP_W-1:0]  req_setpoint_m1 = '0;
   logic signed [SP_W-1:0]  req_setpoint_m2 = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [CMP_W-1:0]        rsp_compare_m1;
   logic [CMP_W-1:0]        rsp_compare_m2;
   logic signed [CUR_W-1:0] rsp_current_m1;
   logic signed [CUR_W-1:0] rsp_current_m2;
   logic                    rsp_volt_sat_m1;
   logic                    rsp_volt_sat_m2;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_AW-1:0]       csr_index = '0;
   logic [CSR_DW-1:0]       csr_wr_data = '0;

   loop_req_type pending[$];
   loop_rsp_type expect_q[$];
   bit           offering = 1'b0;
   bit           snd_idles = 1'b1;
   bit           rsp_idles = 1'b1;
   int           mismatches = 0;
   int unsigned  cycle_count = 0;

   int fs_mv = 3000;
   int ofs_mv[2] = '{1250, 1250};
   int sense_gain[2] = '{65536, 65536};
   int coef_new = 65536;
   int coef_old = -65536;
   int pwm_half = 1800;
   int prev_err[2] = '{0, 0};
   int prev_volt[2] = '{0, 0};

   dual_motor_current_pi_pwm i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_adc_m1      (req_adc_m1),
      .req_adc_m2      (req_adc_m2),
      .req_setpoint_m1 (req_setpoint_m1),
      .req_setpoint_m2 (req_setpoint_m2),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_compare_m1  (rsp_compare_m1),
      .rsp_compare_m2  (rsp_compare_m2),
      .rsp_current_m1  (rsp_current_m1),
      .rsp_current_m2  (rsp_current_m2),
      .rsp_volt_sat_m1 (rsp_volt_sat_m1),
      .rsp_volt_sat_m2 (rsp_volt_sat_m2),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      else if (r < 92) return $urandom_range(3, 1);
      else return $urandom_range(120, 15);
   endfunction

   function automatic motor_out_type step_motor(int m, logic [ADC_W-1:0] adc,
                                                logic signed [SP_W-1:0] sp);
      longint        mv, cur, err, volt, vduty, setp;
      motor_out_type o;
      mv = adc;
      mv = mv * fs_mv / ADC_FULL;
      cur = (longint'(sense_gain[m]) * (mv - ofs_mv[m])) / 65536;
      if (cur > 32767) cur = 32767;
      else if (cur < -32768) cur = -32768;
      setp = sp;
      err = setp - cur;
      volt = longint'(prev_volt[m]) + longint'(coef_new) * err
             + longint'(coef_old) * prev_err[m];
      o.sat = (volt > VOLT_LIM) || (volt < -VOLT_LIM);
      if (volt > VOLT_LIM) volt = VOLT_LIM;
      else if (volt < -VOLT_LIM) volt = -VOLT_LIM;
      prev_err[m] = int'(err);
      prev_volt[m] = int'(volt);
      vduty = volt;
      if (vduty > DUTY_LIM) vduty = DUTY_LIM;
      else if (vduty < -DUTY_LIM) vduty = -DUTY_LIM;
      o.compare = CMP_W'((longint'(pwm_half) * (VOLT_LIM + vduty)) / VOLT_LIM);
      o.current = cur[CUR_W-1:0];
      return o;
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want,
                                       logic signed [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic write_reg(csr_index_type idx, logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_FULL_SCALE: fs_mv = value[FS_W-1:0];
         CSR_OFFSET_M1:  ofs_mv[0] = value[OFS_W-1:0];
         CSR_OFFSET_M2:  ofs_mv[1] = value[OFS_W-1:0];
         CSR_GAIN_M1:    sense_gain[0] = value[GAIN_W-1:0];
         CSR_GAIN_M2:    sense_gain[1] = value[GAIN_W-1:0];
         CSR_COEF_NEW:   coef_new = $signed(value[COEF_W-1:0]);
         CSR_COEF_OLD:   coef_old = $signed(value[COEF_W-1:0]);
         CSR_PWM_HALF:   pwm_half = value[PWM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(int fs, int o1, int o2, int g1, int g2, int cn, int co,
                              int ph);
      write_reg(CSR_FULL_SCALE, CSR_DW'(fs));
      write_reg(CSR_OFFSET_M1, CSR_DW'(o1));
      write_reg(CSR_OFFSET_M2, CSR_DW'(o2));
      write_reg(CSR_GAIN_M1, CSR_DW'(g1));
      write_reg(CSR_GAIN_M2, CSR_DW'(g2));
      write_reg(CSR_COEF_NEW, CSR_DW'(cn));
      write_reg(CSR_COEF_OLD, CSR_DW'(co));
      write_reg(CSR_PWM_HALF, CSR_DW'(ph));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending.size() != 0 || offering || expect_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic add_req(int a1, int a2, int s1, int s2);
      loop_req_type r;
      r.adc_m1 = ADC_W'(a1);
      r.adc_m2 = ADC_W'(a2);
      r.sp_m1 = SP_W'(s1);
      r.sp_m2 = SP_W'(s2);
      pending.push_back(r);
   endtask

   // request driver: predict on acceptance, then gap or present the next request
   always @(posedge clock) begin : req_driver
      loop_req_type  cur_req;
      loop_rsp_type  exp_rsp;
      motor_out_type m1, m2;
      int            gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            m1 = step_motor(0, cur_req.adc_m1, cur_req.sp_m1);
            m2 = step_motor(1, cur_req.adc_m2, cur_req.sp_m2);
            exp_rsp.compare_m1 = m1.compare;
            exp_rsp.compare_m2 = m2.compare;
            exp_rsp.current_m1 = m1.current;
            exp_rsp.current_m2 = m2.current;
            exp_rsp.volt_sat_m1 = m1.sat;
            exp_rsp.volt_sat_m2 = m2.sat;
            expect_q.push_back(exp_rsp);
            offering = 1'b0;
            gap_left = snd_idles ? idle_cycles() : 0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() != 0) begin
               cur_req = pending.pop_front();
               offering = 1'b1;
               req_adc_m1 <= cur_req.adc_m1;
               req_adc_m2 <= cur_req.adc_m2;
               req_setpoint_m1 <= cur_req.sp_m1;
               req_setpoint_m2 <= cur_req.sp_m2;
            end
         end
         req_valid <= offering;
      end
   end

   // result monitor: check against the oldest prediction, then pick the next stall
   always @(posedge clock) begin : rsp_monitor
      loop_rsp_type want;
      int           results_seen;
      int           stall_left;
      bit           held;
      if (reset) begin
         rsp_stall <= 1'b0;
         results_seen = 0;
         stall_left = 0;
         held = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expect_q.size() == 0) begin
               $error("result with no request outstanding");
               mismatches++;
            end else begin
               want = expect_q.pop_front();
               check_field("compare_m1", want.compare_m1, rsp_compare_m1);
               check_field("compare_m2", want.compare_m2, rsp_compare_m2);
               check_field("current_m1", $signed(want.current_m1), rsp_current_m1);
               check_field("current_m2", $signed(want.current_m2), rsp_current_m2);
               check_field("volt_sat_m1", want.volt_sat_m1, rsp_volt_sat_m1);
               check_field("volt_sat_m2", want.volt_sat_m2, rsp_volt_sat_m2);
            end
         end
         if (!held && results_seen == HOLD_AT) begin
            held = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left == 0) stall_left = rsp_idles ? idle_cycles() : 0;
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      int cn;
      int a1, a2, s1, s2;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_req(0, 0, 0, 0);
      add_req(4095, 4095, 32767, -32768);
      add_req(4095, 0, -32768, 32767);
      add_req(1706, 1706, 0, 0);
      add_req(2048, 2048, 100, -100);
      add_req(0, 4095, -32768, -32768);
      add_req(4095, 0, 32767, 32767);
      add_req(1706, 1706, 0, 0);
      wait_idle();

      // positive current overflow on motor 1, zero gain on motor 2
      load_config(4095, 0, 4095, 16777215, 0, 8388607, -8388608, 32767);
      add_req(4095, 4095, 0, 0);
      add_req(0, 0, 0, 0);
      add_req(4095, 1, -32768, 32767);
      add_req(2048, 2048, 32767, -32768);
      add_req(1, 4095, 1, -1);
      wait_idle();

      // negative current overflow on motor 1, positive on motor 2
      load_config(4095, 4095, 0, 16777215, 16777215, -8388608, 8388607, 0);
      add_req(0, 4095, 0, 0);
      add_req(4095, 0, 32767, -32768);
      add_req(0, 4095, -32768, 32767);
      add_req(2730, 2730, 0, 0);
      add_req(1, 1, -1, 1);
      wait_idle();

      // zero full scale and zero coefficients
      load_config(0, 2047, 2048, 65536, 65536, 0, 0, 32767);
      add_req(4095, 4095, 1000, -1000);
      add_req(0, 0, 0, 0);
      add_req(2048, 1024, -32768, 32767);
      wait_idle();

      for (phase = 0; phase < 6; phase++) begin
         snd_idles = (phase != 0) && ($urandom_range(3) != 0);
         rsp_idles = ($urandom_range(3) != 0);
         cn = ($urandom_range(4) == 0) ? int'($urandom) : $urandom_range(131072, 8192);
         load_config(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(3300, 2500),
                     ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(2000, 1000),
                     ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(2000, 1000),
                     ($urandom_range(4) == 0) ? $urandom_range(24'hFFFFFF)
                                              : $urandom_range(98304, 16384),
                     ($urandom_range(4) == 0) ? $urandom_range(24'hFFFFFF)
                                              : $urandom_range(98304, 16384),
                     cn,
                     ($urandom_range(4) == 0) ? int'($urandom)
                                              : -int'($urandom_range(131072)),
                     $urandom_range(32767));
         for (n = 0; n < 80; n++) begin
            a1 = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(2400, 1000);
            a2 = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(2400, 1000);
            s1 = ($urandom_range(5) == 0) ? int'($urandom) : $urandom_range(1200) - 600;
            s2 = ($urandom_range(5) == 0) ? int'($urandom) : $urandom_range(1200) - 600;
            add_req(a1, a2, s1, s2);
         end
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (mismatches == 0 && expect_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
